// File: src/ima_pkg.sv
`timescale 1ns / 1ps

package ima_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_DECODE = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;

    localparam int          SAMPLE_W = 16;
    localparam int          CODE_W   = 4;
    localparam int          INDEX_W  = 7;
    localparam int          STEP_W   = 15;
    localparam logic [6:0]  IDX_MAX  = 7'd88;

    // One result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CODE_W-1:0]          code;
        logic [INDEX_W-1:0]         index;
    } t_result;

    // Quantizer step size for a step index
    function automatic logic [STEP_W-1:0] step_size(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    // Index adjustment for a code: small codes step down, large ones step up
    function automatic logic signed [4:0] index_adjust(input logic [CODE_W-1:0] code);
        logic signed [4:0] a;
        begin
            case (code[2:0])
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage

// File: src/ima_step.sv
`timescale 1ns / 1ps

module ima_step (
    input  logic [1:0]                          i_op,
    input  logic [ima_pkg::CODE_W-1:0]          i_code,
    input  logic signed [ima_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [ima_pkg::INDEX_W-1:0]         i_index_load,
    input  logic signed [ima_pkg::SAMPLE_W-1:0] i_pred,
    input  logic [ima_pkg::INDEX_W-1:0]         i_index,
    output ima_pkg::t_result                    o_next
);

    logic [ima_pkg::STEP_W-1:0] step;
    logic signed [16:0]         gap;
    logic [16:0]                mag;
    logic [16:0]                rem1;
    logic [16:0]                rem2;
    logic [3:0]                 enc_code;
    logic [3:0]                 code;
    logic [16:0]                diff;
    logic signed [17:0]         pred_sum;
    logic signed [15:0]         pred_sat;
    logic signed [7:0]          idx_sum;
    logic [6:0]                 idx_sat;
    logic [6:0]                 idx_load;

    assign step = ima_pkg::step_size(i_index);

    // Quantize the gap between the sample and the predictor
    always_comb begin
        gap         = {i_sample[15], i_sample} - {i_pred[15], i_pred};
        enc_code    = '0;
        enc_code[3] = gap[16];
        mag         = gap[16] ? 17'(-gap) : 17'(gap);
        rem1        = mag;
        if (mag >= {2'b00, step}) begin
            enc_code[2] = 1'b1;
            rem1        = mag - {2'b00, step};
        end
        rem2 = rem1;
        if (rem1 >= {3'b000, step[14:1]}) begin
            enc_code[1] = 1'b1;
            rem2        = rem1 - {3'b000, step[14:1]};
        end
        enc_code[0] = (rem2 >= {4'b0000, step[14:2]});
    end

    assign code = (i_op == ima_pkg::OP_ENCODE) ? enc_code : i_code;

    // Rebuild the difference and move the predictor with saturation
    always_comb begin
        diff = {5'b0, step[14:3]};
        if (code[0]) diff = diff + {4'b0, step[14:2]};
        if (code[1]) diff = diff + {3'b0, step[14:1]};
        if (code[2]) diff = diff + {2'b0, step};
        if (code[3]) pred_sum = {{2{i_pred[15]}}, i_pred} - $signed({1'b0, diff});
        else         pred_sum = {{2{i_pred[15]}}, i_pred} + $signed({1'b0, diff});
        if (pred_sum < -18'sd32768)     pred_sat = 16'sh8000;
        else if (pred_sum > 18'sd32767) pred_sat = 16'sh7fff;
        else                            pred_sat = pred_sum[15:0];
    end

    // Move the step index and clamp it
    always_comb begin
        idx_sum = $signed({1'b0, i_index}) + 8'(ima_pkg::index_adjust(code));
        if (idx_sum < 8'sd0)                               idx_sat = '0;
        else if (idx_sum > $signed({1'b0, ima_pkg::IDX_MAX})) idx_sat = ima_pkg::IDX_MAX;
        else                                               idx_sat = idx_sum[6:0];
    end

    assign idx_load = (i_index_load > ima_pkg::IDX_MAX) ? ima_pkg::IDX_MAX : i_index_load;

    // Pick the result for the operation
    always_comb begin
        case (i_op)
            ima_pkg::OP_DECODE, ima_pkg::OP_ENCODE: begin
                o_next.sample = pred_sat;
                o_next.code   = code;
                o_next.index  = idx_sat;
            end
            ima_pkg::OP_LOAD: begin
                o_next.sample = i_sample;
                o_next.code   = '0;
                o_next.index  = idx_load;
            end
            default: begin
                o_next.sample = i_pred;
                o_next.code   = '0;
                o_next.index  = i_index;
            end
        endcase
    end

endmodule

// File: src/ima_adpcm_codec.sv
`timescale 1ns / 1ps
// A word accepted into the input register passes through the combinational step into the
// result register, where it is held until taken. Throughput: one word per cycle while the
// output is not stalled; predictor and index update in the single combinational step
// between the input register and the result register.
// Reset (i_rst_n low, synchronous): predictor and step index clear to 0, both stages empty.

module ima_adpcm_codec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [ima_pkg::CODE_W-1:0]          i_code_in,
    input  logic signed [ima_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [ima_pkg::INDEX_W-1:0]         i_index_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ima_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [ima_pkg::CODE_W-1:0]          o_code_out,
    output logic [ima_pkg::INDEX_W-1:0]         o_index_out
);

    logic                                r_s1_valid;
    logic [1:0]                          r_s1_op;
    logic [ima_pkg::CODE_W-1:0]          r_s1_code;
    logic signed [ima_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [ima_pkg::INDEX_W-1:0]         r_s1_index;
    logic signed [ima_pkg::SAMPLE_W-1:0] r_pred;
    logic [ima_pkg::INDEX_W-1:0]         r_index;
    logic                                r_out_valid;
    ima_pkg::t_result                    r_out;
    ima_pkg::t_result                    n_out;
    logic                                out_free;
    logic                                s1_adv;
    logic                                in_acc;

    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;
    assign in_acc   = i_valid && o_ready;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (in_acc) begin
            r_s1_op     <= i_op;
            r_s1_code   <= i_code_in;
            r_s1_sample <= i_sample_in;
            r_s1_index  <= i_index_in;
        end
    end

    ima_step u_step (
        .i_op         (r_s1_op),
        .i_code       (r_s1_code),
        .i_sample     (r_s1_sample),
        .i_index_load (r_s1_index),
        .i_pred       (r_pred),
        .i_index      (r_index),
        .o_next       (n_out)
    );

    // Advance the codec state and the result register together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= '0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_pred  <= n_out.sample;
                r_index <= n_out.index;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out.sample;
    assign o_code_out   = r_out.code;
    assign o_index_out  = r_out.index;

    // Step index never leaves its table range
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= ima_pkg::IDX_MAX)
        else $error("step index out of range");

    // A fresh result carries the updated predictor and index
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> (o_sample_out == r_pred) && (o_index_out == r_index))
        else $error("result does not match codec state");

    // A load sets the predictor to the loaded sample
    a_load_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_op == ima_pkg::OP_LOAD) |=> r_pred == $past(r_s1_sample))
        else $error("load did not set predictor");

    // Decode echoes the input code
    a_decode_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_op == ima_pkg::OP_DECODE) |=> o_code_out == $past(r_s1_code))
        else $error("decode code not echoed");

endmodule
